[rtl/core/aes_pkg.sv]
// Shared types and character constants for the ANSI escape stripper.
package aes_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_CSI     = 3'd2,
        MODE_OSC     = 3'd3,
        MODE_OSC_ESC = 3'd4
    } mode_t;

    typedef struct packed {
        logic       emit;
        logic [7:0] data;
    } result_t;

    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_FINAL_LO  = 8'h40;
    localparam logic [7:0] CH_FINAL_HI  = 8'h7E;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

endpackage

[rtl/core/aes_parser.sv]
// Escape sequence parser: mode and line break state with the per-byte decision.
module aes_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          in_byte,
    input  logic                start_of_text,
    output aes_pkg::result_t    result
);

    aes_pkg::mode_t mode_reg;
    aes_pkg::mode_t mode_next;
    logic           cr_reg;
    logic           cr_next;
    logic           nl_reg;
    logic           nl_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= aes_pkg::MODE_NORMAL;
            cr_reg   <= 1'b0;
            nl_reg   <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            cr_reg   <= cr_next;
            nl_reg   <= nl_next;
        end
    end

    always_comb
    begin
        aes_pkg::mode_t mode_cur;
        logic           cr_cur;
        logic           nl_cur;

        mode_cur = start_of_text ? aes_pkg::MODE_NORMAL : mode_reg;
        cr_cur   = start_of_text ? 1'b0 : cr_reg;
        nl_cur   = start_of_text ? 1'b0 : nl_reg;

        mode_next   = mode_cur;
        cr_next     = cr_cur;
        result.emit = 1'b0;
        result.data = in_byte;

        case (mode_cur)
            aes_pkg::MODE_ESC:
            begin
                if (in_byte == aes_pkg::CH_LBRACKET)
                    mode_next = aes_pkg::MODE_CSI;
                else if (in_byte == aes_pkg::CH_RBRACKET)
                    mode_next = aes_pkg::MODE_OSC;
                else
                    mode_next = aes_pkg::MODE_NORMAL;
            end
            aes_pkg::MODE_CSI:
            begin
                if (in_byte inside {[aes_pkg::CH_FINAL_LO:aes_pkg::CH_FINAL_HI]})
                    mode_next = aes_pkg::MODE_NORMAL;
            end
            aes_pkg::MODE_OSC:
            begin
                if (in_byte == aes_pkg::CH_BEL)
                    mode_next = aes_pkg::MODE_NORMAL;
                else if (in_byte == aes_pkg::CH_ESC)
                    mode_next = aes_pkg::MODE_OSC_ESC;
            end
            aes_pkg::MODE_OSC_ESC:
            begin
                mode_next = (in_byte == aes_pkg::CH_BACKSLASH) ?
                            aes_pkg::MODE_NORMAL : aes_pkg::MODE_OSC;
            end
            default:
            begin
                mode_next = aes_pkg::MODE_NORMAL;
                if (in_byte == aes_pkg::CH_ESC)
                begin
                    mode_next = aes_pkg::MODE_ESC;
                end
                else if (in_byte == aes_pkg::CH_CR)
                begin
                    result.emit = !nl_cur;
                    result.data = aes_pkg::CH_LF;
                    cr_next     = 1'b1;
                end
                else if (in_byte == aes_pkg::CH_LF)
                begin
                    result.emit = !cr_cur;
                    cr_next     = 1'b0;
                end
                else if (in_byte == aes_pkg::CH_TAB || in_byte >= aes_pkg::CH_SPACE)
                begin
                    result.emit = 1'b1;
                    cr_next     = 1'b0;
                end
            end
        endcase

        nl_next = result.emit ? (result.data == aes_pkg::CH_LF) : nl_cur;
    end

endmodule

[rtl/core/ansi_escape_stripper_top.sv]
// Top level of the ANSI escape stripper: input register, parser and result register.
//
//  Channel  Direction  Handshake            Payload
//  in       sink       in_valid / in_ready  in_byte[7:0], start_of_text
//  out      source     out_valid/out_ready  out_byte[7:0]
//
// One request is taken per cycle unless the input side is stalled; an emitted byte passes
// through the input register and then the result register to out_byte. The input register
// feeds the parser, whose state is updated in the same cycle the result register is loaded.
// Reset returns the parser to normal text with no line break history.
// A stalled result holds the input register; the input side stalls only when both are full
// and the result is not taken in that cycle.
module ansi_escape_stripper_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       start_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte
);

    logic              stage_valid_reg;
    logic [7:0]        stage_byte_reg;
    logic              stage_start_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              advance;
    aes_pkg::result_t  result;

    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_byte_reg  <= in_byte;
            stage_start_reg <= start_of_text;
        end
    end

    aes_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_byte       (stage_byte_reg),
        .start_of_text (stage_start_reg),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= advance && result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            out_byte_reg <= result.data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

endmodule

[rtl/core/aes_checker.sv]
// Port-level checks for the ANSI escape stripper and their bind to the top level.
module aes_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("Result request changed while stalled.");

    a_out_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_byte == aes_pkg::CH_LF || out_byte == aes_pkg::CH_TAB ||
                       out_byte >= aes_pkg::CH_SPACE))
        else $error("Control byte other than tab or line feed was emitted.");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("Input stalled while the result register was empty.");

    a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("Input stalled in a cycle where the result was taken.");

endmodule

bind ansi_escape_stripper_top aes_checker u_aes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte)
);

[verif/ansi_escape_stripper_top_tb.sv]
// Self-checking testbench for ansi_escape_stripper_top with a byte-level scoreboard.
module ansi_escape_stripper_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 620;
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_CYCLES     = 120;
    localparam int HOLD_AT         = 430;
    localparam int CALM_FIRST      = 200;
    localparam int CALM_LAST       = 350;
    localparam int DRAIN_CYCLES    = 8;

    // Tracks the stripper state and the cleaned bytes still owed by the block.
    class clean_text_board;
        aes_pkg::mode_t mode;
        bit             cr_seen;
        bit             newline_last;
        logic [7:0]     expected_text[$];
        int             errors;
        int             bytes_checked;
        int             text_starts;

        function new();
            mode          = aes_pkg::MODE_NORMAL;
            cr_seen       = 1'b0;
            newline_last  = 1'b0;
            errors        = 0;
            bytes_checked = 0;
            text_starts   = 0;
        endfunction

        function void emit_byte(logic [7:0] b);
            expected_text = {expected_text, b};
            newline_last = (b == aes_pkg::CH_LF);
        endfunction

        function void take_raw_byte(logic [7:0] b, logic fresh);
            if (fresh)
            begin
                mode         = aes_pkg::MODE_NORMAL;
                cr_seen      = 1'b0;
                newline_last = 1'b0;
                text_starts++;
            end
            case (mode)
                aes_pkg::MODE_ESC:
                begin
                    if (b == aes_pkg::CH_LBRACKET)
                        mode = aes_pkg::MODE_CSI;
                    else if (b == aes_pkg::CH_RBRACKET)
                        mode = aes_pkg::MODE_OSC;
                    else
                        mode = aes_pkg::MODE_NORMAL;
                end
                aes_pkg::MODE_CSI:
                begin
                    if (b >= aes_pkg::CH_FINAL_LO && b <= aes_pkg::CH_FINAL_HI)
                        mode = aes_pkg::MODE_NORMAL;
                end
                aes_pkg::MODE_OSC:
                begin
                    if (b == aes_pkg::CH_BEL)
                        mode = aes_pkg::MODE_NORMAL;
                    else if (b == aes_pkg::CH_ESC)
                        mode = aes_pkg::MODE_OSC_ESC;
                end
                aes_pkg::MODE_OSC_ESC:
                begin
                    if (b == aes_pkg::CH_BACKSLASH)
                        mode = aes_pkg::MODE_NORMAL;
                    else
                        mode = aes_pkg::MODE_OSC;
                end
                default:
                begin
                    mode = aes_pkg::MODE_NORMAL;
                    if (b == aes_pkg::CH_ESC)
                        mode = aes_pkg::MODE_ESC;
                    else if (b == aes_pkg::CH_CR)
                    begin
                        if (!newline_last)
                            emit_byte(aes_pkg::CH_LF);
                        cr_seen = 1'b1;
                    end
                    else if (b == aes_pkg::CH_LF)
                    begin
                        if (!cr_seen)
                            emit_byte(aes_pkg::CH_LF);
                        cr_seen = 1'b0;
                    end
                    else if (b == aes_pkg::CH_TAB || b >= aes_pkg::CH_SPACE)
                    begin
                        emit_byte(b);
                        cr_seen = 1'b0;
                    end
                end
            endcase
        endfunction

        function void check_clean_byte(logic [7:0] actual);
            logic [7:0] want;
            bytes_checked++;
            if (expected_text.size() == 0)
            begin
                $error("out_byte: expected nothing, actual 0x%02h", actual);
                errors++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (actual !== want)
                begin
                    $error("out_byte: expected 0x%02h, actual 0x%02h", want, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_text.size();
        endfunction
    endclass

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte       = 8'h00;
    logic       start_of_text = 1'b0;
    logic       out_valid;
    logic       out_ready     = 1'b0;
    logic [7:0] out_byte;

    clean_text_board board;
    int sent_total  = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int idle_cycles = 0;

    logic [8:0] directed_bytes[] = '{
        {1'b1, 8'h0D}, {1'b0, 8'h0A}, {1'b0, 8'h09}, {1'b0, 8'h0D}, {1'b0, 8'h1B},
        {1'b0, 8'h5B}, {1'b0, 8'h40}, {1'b0, 8'h0A}, {1'b0, 8'h0A}, {1'b0, 8'h0D},
        {1'b0, 8'h1B}, {1'b0, 8'h5D}, {1'b0, 8'h1B}, {1'b0, 8'h41}, {1'b0, 8'h07},
        {1'b0, 8'h1B}, {1'b0, 8'h1B}, {1'b0, 8'hFF}, {1'b0, 8'h1B}, {1'b0, 8'h5D},
        {1'b0, 8'h1B}, {1'b0, 8'h5C}, {1'b0, 8'h1B}, {1'b0, 8'h5B}, {1'b1, 8'h00},
        {1'b0, 8'h1B}, {1'b0, 8'h78}
    };

    ansi_escape_stripper_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .start_of_text (start_of_text),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte)
    );

    always #5 clk = ~clk;

    function bit calm();
        return (sent_total >= CALM_FIRST && sent_total < CALM_LAST) || hold_left != 0;
    endfunction

    function logic pick_start();
        return ($urandom_range(99) < 2);
    endfunction

    task automatic send_request(input logic [7:0] b, input logic fresh);
        @(negedge clk);
        while (!calm() && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            in_byte  <= $urandom;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        in_byte       <= b;
        start_of_text <= fresh;
        do
            @(posedge clk);
        while (!in_ready);
        board.take_raw_byte(b, fresh);
        sent_total++;
    endtask

    task automatic send_random_token();
        int         kind;
        logic [7:0] b;
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            repeat ($urandom_range(1, 6))
            begin
                b = ($urandom_range(9) == 0) ? aes_pkg::CH_TAB :
                                               8'($urandom_range(8'h20, 8'hFF));
                send_request(b, pick_start());
            end
        end
        else if (kind < 47)
        begin
            repeat ($urandom_range(1, 3))
                send_request($urandom_range(1) ? aes_pkg::CH_CR : aes_pkg::CH_LF,
                             pick_start());
        end
        else if (kind < 65)
        begin
            send_request(aes_pkg::CH_ESC, pick_start());
            send_request(aes_pkg::CH_LBRACKET, pick_start());
            repeat ($urandom_range(0, 4))
                send_request(8'($urandom_range(8'h20, 8'h3F)), pick_start());
            send_request(8'($urandom_range(aes_pkg::CH_FINAL_LO, aes_pkg::CH_FINAL_HI)),
                         pick_start());
        end
        else if (kind < 78)
        begin
            send_request(aes_pkg::CH_ESC, pick_start());
            send_request(aes_pkg::CH_RBRACKET, pick_start());
            repeat ($urandom_range(0, 5))
            begin
                if ($urandom_range(7) == 0)
                begin
                    send_request(aes_pkg::CH_ESC, pick_start());
                    send_request(8'($urandom_range(8'h00, 8'hFF)), pick_start());
                end
                else
                    send_request(8'($urandom_range(8'h20, 8'hFF)), pick_start());
            end
            if ($urandom_range(1))
                send_request(aes_pkg::CH_BEL, pick_start());
            else
            begin
                send_request(aes_pkg::CH_ESC, pick_start());
                send_request(aes_pkg::CH_BACKSLASH, pick_start());
            end
        end
        else if (kind < 84)
        begin
            send_request(aes_pkg::CH_ESC, pick_start());
            send_request(8'($urandom_range(8'h00, 8'hFF)), pick_start());
        end
        else if (kind < 92)
            send_request(8'($urandom_range(8'h00, 8'h1F)), pick_start());
        else
            send_request(8'($urandom_range(8'h00, 8'hFF)), pick_start());
    endtask

    always @(negedge clk)
    begin
        if (rst_n && !hold_done && sent_total >= HOLD_AT)
        begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && (calm() || $urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_clean_byte(out_byte);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("ansi_escape_stripper_top_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        board = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_request(directed_bytes[i][7:0], directed_bytes[i][8]);
        while (sent_total < directed_bytes.size() + RANDOM_REQUESTS)
            send_random_token();

        @(negedge clk);
        in_valid      <= 1'b0;
        start_of_text <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d raw bytes in, %0d text starts, %0d clean bytes checked.",
                 sent_total, board.text_starts, board.bytes_checked);
        $display("Summary: CSI, OSC and bare escape sequences mixed with text and line breaks.");
        if (board.errors == 0)
            $display("ansi_escape_stripper_top_tb: done, clean");
        else
            $display("ansi_escape_stripper_top_tb: done, errors");
        $finish;
    end

endmodule
